// ----- src/cts_pkg.sv -----
// ----------------------------------------------------------------------------
// Command tokenizer package
// Shared types and constants: result records, per-byte result bundles and
// the character codes that the parser recognizes.
// ----------------------------------------------------------------------------
package cts_pkg;

	// Default limit on the number of tokens in one line.
	localparam int MAX_TOKENS_DEF = 1024;

	// One input byte causes at most this many results.
	localparam int MAX_RES = 4;

	// Depth of the bundle queue between parser and output side.
	localparam int FIFO_DEPTH = 4;

	// Characters with a meaning of their own.
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_HIGH  = 8'h80;

	// Kind of one result.
	typedef enum logic [1:0] {
		KIND_CHAR = 2'd0,
		KIND_END  = 2'd1,
		KIND_DONE = 2'd2
	} kind_t;

	// One result as it leaves the block.
	typedef struct packed {
		kind_t       kind;
		logic [10:0] value;
		logic [9:0]  token_index;
	} result_t;

	// All results that one input byte causes, oldest in entry zero.
	typedef struct packed {
		logic [2:0]                 n;
		result_t [MAX_RES-1:0]      res;
	} bundle_t;

	// Append one result to a bundle; results past the limit are dropped.
	function automatic bundle_t add_res(bundle_t b, kind_t k, logic [10:0] v,
			logic [9:0] idx);
		bundle_t r;
		r = b;
		if (r.n < 3'(MAX_RES)) begin
			r.res[r.n[1:0]].kind = k;
			r.res[r.n[1:0]].value = v;
			r.res[r.n[1:0]].token_index = idx;
			r.n = r.n + 3'd1;
		end
		return r;
	endfunction

endpackage

// ----- src/cts_front.sv -----
// ----------------------------------------------------------------------------
// Command tokenizer front end
// Parses one byte per transfer and produces the bundle of results that the
// byte causes. Holds the parser mode, the pending slash and the token count.
// ----------------------------------------------------------------------------
module cts_front #(
	parameter int MAX_TOKENS = cts_pkg::MAX_TOKENS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic [7:0]       ch,
	input  logic             last,
	output cts_pkg::bundle_t bundle,
	output logic             bundle_valid
);
	import cts_pkg::*;

	localparam int CW = $clog2(MAX_TOKENS + 1);

	typedef enum logic [5:0] {
		M_BETWEEN = 6'b000001,
		M_PLAIN   = 6'b000010,
		M_QUOTED  = 6'b000100,
		M_COMMENT = 6'b001000,
		M_STAR    = 6'b010000,
		M_DONE    = 6'b100000
	} mode_t;

	mode_t           mode_q;
	logic            slash_q;
	logic [CW-1:0]   cnt_q;

	mode_t           m;
	logic            sh;
	logic [CW-1:0]   cnt;
	bundle_t         b;
	logic            disp;
	logic            sep;
	logic [CW-1:0]   cnt_dec;
	logic [9:0]      idx;
	logic            at_limit;

	// Walk the byte through the parser, collecting results in order.
	always_comb begin
		m = mode_q;
		sh = slash_q;
		cnt = cnt_q;
		b = '0;
		disp = 1'b1;
		sep = (ch <= CH_SPACE) || (ch >= CH_HIGH);
		cnt_dec = '0;
		idx = '0;
		at_limit = 1'b0;

		// A held slash is resolved by this byte.
		if (sh) begin
			if (ch == CH_SLASH) begin
				// Line comment: close the open token and finish.
				sh = 1'b0;
				disp = 1'b0;
				cnt_dec = cnt - 1'b1;
				idx = (cnt == '0) ? '0 : 10'(cnt_dec);
				if (m == M_PLAIN) begin
					b = add_res(b, KIND_END, '0, idx);
				end
				b = add_res(b, KIND_DONE, 11'(cnt), '0);
				m = M_DONE;
			end else if (ch == CH_STAR) begin
				// Block comment opens; a plain token closes first.
				sh = 1'b0;
				disp = 1'b0;
				if (m == M_PLAIN) begin
					cnt_dec = cnt - 1'b1;
					idx = (cnt == '0) ? '0 : 10'(cnt_dec);
					b = add_res(b, KIND_END, '0, idx);
					at_limit = (cnt >= CW'(MAX_TOKENS));
					if (at_limit) begin
						b = add_res(b, KIND_DONE, 11'(cnt), '0);
						m = M_DONE;
					end else begin
						m = M_BETWEEN;
					end
				end
				if (m != M_DONE) begin
					m = M_STAR;
				end
			end else begin
				// Ordinary slash: it becomes a token character.
				sh = 1'b0;
				if (m == M_BETWEEN) begin
					cnt = cnt + 1'b1;
					m = M_PLAIN;
				end
				cnt_dec = cnt - 1'b1;
				idx = (cnt == '0) ? '0 : 10'(cnt_dec);
				b = add_res(b, KIND_CHAR, 11'(CH_SLASH), idx);
			end
		end

		// Regular handling of the byte.
		if (disp) begin
			unique case (m)
				M_BETWEEN: begin
					if (ch == CH_NUL) begin
						b = add_res(b, KIND_DONE, 11'(cnt), '0);
						m = M_DONE;
						sh = 1'b0;
					end else if (sep) begin
						m = M_BETWEEN;
					end else if (ch == CH_QUOTE) begin
						cnt = cnt + 1'b1;
						m = M_QUOTED;
					end else if (ch == CH_SLASH) begin
						sh = 1'b1;
					end else begin
						cnt = cnt + 1'b1;
						m = M_PLAIN;
						cnt_dec = cnt - 1'b1;
						idx = (cnt == '0) ? '0 : 10'(cnt_dec);
						b = add_res(b, KIND_CHAR, 11'(ch), idx);
					end
				end
				M_PLAIN, M_QUOTED: begin
					cnt_dec = cnt - 1'b1;
					idx = (cnt == '0) ? '0 : 10'(cnt_dec);
					at_limit = (cnt >= CW'(MAX_TOKENS));
					if (ch == CH_NUL) begin
						b = add_res(b, KIND_END, '0, idx);
						b = add_res(b, KIND_DONE, 11'(cnt), '0);
						m = M_DONE;
						sh = 1'b0;
					end else if (ch == CH_QUOTE || (m == M_PLAIN && sep)) begin
						// The token closes; a quote in a plain token opens
						// a quoted one unless the limit was reached.
						b = add_res(b, KIND_END, '0, idx);
						if (at_limit) begin
							b = add_res(b, KIND_DONE, 11'(cnt), '0);
							m = M_DONE;
							sh = 1'b0;
						end else if (m == M_PLAIN && ch == CH_QUOTE) begin
							cnt = cnt + 1'b1;
							m = M_QUOTED;
						end else begin
							m = M_BETWEEN;
						end
					end else if (m == M_PLAIN && ch == CH_SLASH) begin
						sh = 1'b1;
					end else begin
						b = add_res(b, KIND_CHAR, 11'(ch), idx);
					end
				end
				M_COMMENT: begin
					if (ch == CH_NUL) begin
						b = add_res(b, KIND_DONE, 11'(cnt), '0);
						m = M_DONE;
						sh = 1'b0;
					end else if (ch == CH_STAR) begin
						m = M_STAR;
					end
				end
				M_STAR: begin
					if (ch == CH_NUL) begin
						b = add_res(b, KIND_DONE, 11'(cnt), '0);
						m = M_DONE;
						sh = 1'b0;
					end else if (ch == CH_SLASH) begin
						m = M_BETWEEN;
					end else if (ch != CH_STAR) begin
						m = M_COMMENT;
					end
				end
				M_DONE: begin
					m = M_DONE;
				end
				default: begin
					m = M_DONE;
				end
			endcase
		end

		// End of line: flush what is open and finish once.
		if (last) begin
			if (m != M_DONE) begin
				if (sh) begin
					sh = 1'b0;
					if (m == M_BETWEEN) begin
						cnt = cnt + 1'b1;
						m = M_PLAIN;
					end
					cnt_dec = cnt - 1'b1;
					idx = (cnt == '0) ? '0 : 10'(cnt_dec);
					b = add_res(b, KIND_CHAR, 11'(CH_SLASH), idx);
				end
				if (m == M_PLAIN || m == M_QUOTED) begin
					cnt_dec = cnt - 1'b1;
					idx = (cnt == '0) ? '0 : 10'(cnt_dec);
					b = add_res(b, KIND_END, '0, idx);
				end
				b = add_res(b, KIND_DONE, 11'(cnt), '0);
			end
			m = M_BETWEEN;
			sh = 1'b0;
			cnt = '0;
		end
	end

	assign bundle = b;
	assign bundle_valid = accept && (b.n != 3'd0);

	// Parser state advances on every accepted byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_BETWEEN;
			slash_q <= 1'b0;
			cnt_q <= '0;
		end else if (accept) begin
			mode_q <= m;
			slash_q <= sh;
			cnt_q <= cnt;
		end
	end

endmodule

// ----- src/cts_fifo.sv -----
// ----------------------------------------------------------------------------
// Command tokenizer bundle queue
// Short first-in first-out queue of result bundles that decouples the
// parser from the output side.
// ----------------------------------------------------------------------------
module cts_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  cts_pkg::bundle_t wr_data,
	input  logic             rd_en,
	output cts_pkg::bundle_t rd_data,
	output logic             full,
	output logic             empty
);
	import cts_pkg::*;

	localparam int PW = $clog2(FIFO_DEPTH);
	localparam int NW = $clog2(FIFO_DEPTH + 1);

	bundle_t         mem_q [FIFO_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [NW-1:0]   count_q;

	// Storage is written at the tail.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign rd_data = mem_q[rd_ptr_q];
	assign full = (count_q == NW'(FIFO_DEPTH));
	assign empty = (count_q == '0);

endmodule

// ----- src/cts_back.sv -----
// ----------------------------------------------------------------------------
// Command tokenizer back end
// Takes bundles from the queue and hands their results out one at a time
// through an output register, marking the last result of each byte.
// ----------------------------------------------------------------------------
module cts_back (
	input  logic             clk,
	input  logic             arst_n,
	input  cts_pkg::bundle_t head,
	input  logic             avail,
	output logic             take,
	output logic             empty,
	input  logic             pop,
	output cts_pkg::result_t res,
	output logic             run_last
);
	import cts_pkg::*;

	logic [1:0]   pos_q;
	logic         out_v_q;
	result_t      out_q;
	logic         last_q;

	logic         load;
	logic         is_end;

	// Load the next result whenever the output register is free or drains.
	assign load = avail && (!out_v_q || pop);
	assign is_end = ({1'b0, pos_q} == (head.n - 3'd1));
	assign take = load && is_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (load) begin
				out_v_q <= 1'b1;
				pos_q <= is_end ? '0 : pos_q + 1'b1;
			end else if (pop) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= head.res[pos_q];
			last_q <= is_end;
		end
	end

	assign empty = !out_v_q;
	assign res = out_q;
	assign run_last = last_q;

endmodule

// ----- src/command_tokenizer_stream_unit.sv -----
// ----------------------------------------------------------------------------
// Command tokenizer stream unit
// Splits a command line, one byte per transfer, into tokens with quotes and
// C-style comments, and reports token characters, token ends and a count.
//
// Input side: a byte transfers at a clock edge with push high and full low.
// Result side: while empty is low the oldest result is on kind, value,
// token_index and run_last; it transfers at an edge with pop high.
// A byte's bundle is registered in the bundle queue; its results then pass
// one at a time through the output register. A byte may cause zero to four
// results; run_last marks the last. One byte per cycle is taken as long as
// the bundle queue (four entries) has room; results leave at one per cycle
// through the output register while pop is high, so bytes with several
// results need one transfer each; the queue absorbs short bursts of them.
// When the receiver stalls, results wait in the output register and queue,
// and full rises once the queue is filled; the parser then holds its state.
// Reset leaves the parser between tokens with a count of zero and all
// queues empty. After the final byte of a line the parser returns to that
// same state by itself.
// ----------------------------------------------------------------------------
module command_tokenizer_stream_unit #(
	parameter int MAX_TOKENS = cts_pkg::MAX_TOKENS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  ch,
	input  logic        last,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  kind,
	output logic [10:0] value,
	output logic [9:0]  token_index,
	output logic        run_last
);
	import cts_pkg::*;

	logic       accept;
	bundle_t    bundle;
	logic       bundle_valid;
	bundle_t    head;
	logic       q_empty;
	logic       take;
	result_t    res;

	assign accept = push && !full;

	// Parser.
	cts_front #(
		.MAX_TOKENS(MAX_TOKENS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.ch          (ch),
		.last        (last),
		.bundle      (bundle),
		.bundle_valid(bundle_valid)
	);

	// Bundle queue.
	cts_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (bundle_valid),
		.wr_data(bundle),
		.rd_en  (take),
		.rd_data(head),
		.full   (full),
		.empty  (q_empty)
	);

	// Result serializer.
	cts_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.avail   (!q_empty),
		.take    (take),
		.empty   (empty),
		.pop     (pop),
		.res     (res),
		.run_last(run_last)
	);

	assign kind = res.kind;
	assign value = res.value;
	assign token_index = res.token_index;

endmodule

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// Command tokenizer stream unit testbench
// Streams command lines into the tokenizer one byte per transfer and checks
// every result against a cycle-free model of the parser. The run starts with
// short hand-written lines. Random lines follow, built mostly from quotes,
// slashes, stars and separators.
// Both sides of the block idle at random, but for a final full-rate phase.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import cts_pkg::*;

	localparam int MAX_TOKENS = MAX_TOKENS_DEF;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 16;
	localparam int ITEMS_PER_PHASE = 95;

	// Parser states of the model.
	typedef enum logic [2:0] {
		MODE_BETWEEN = 3'd0,
		MODE_PLAIN   = 3'd1,
		MODE_QUOTED  = 3'd2,
		MODE_COMMENT = 3'd3,
		MODE_STAR    = 3'd4,
		MODE_DONE    = 3'd5
	} parse_mode_t;

	// One result with all of its fields.
	typedef struct packed {
		kind_t       kind;
		logic [10:0] value;
		logic [9:0]  token_index;
		logic        run_last;
	} token_result_t;

	// Model of the tokenizer and the store of results still to come.
	class token_scoreboard;
		parse_mode_t mode;
		bit slash_held;
		int unsigned token_count;
		token_result_t byte_results[$];
		token_result_t awaited[$];
		int mismatches;

		function new();
			mode = MODE_BETWEEN;
			slash_held = 1'b0;
			token_count = 0;
			mismatches = 0;
		endfunction

		function void emit(kind_t k, logic [10:0] v, int unsigned idx);
			token_result_t r;
			if (byte_results.size() < MAX_RES) begin
				r.kind = k;
				r.value = v;
				r.token_index = idx[9:0];
				r.run_last = 1'b0;
				byte_results.push_back(r);
			end
		endfunction

		function int unsigned cur_index();
			return (token_count != 0) ? token_count - 1 : 0;
		endfunction

		function void end_token();
			emit(KIND_END, 11'd0, cur_index());
		endfunction

		function void finish_line();
			emit(KIND_DONE, 11'(token_count), 0);
			mode = MODE_DONE;
			slash_held = 1'b0;
		endfunction

		// A closed token may use up the token limit and end the line.
		function void close_token();
			end_token();
			if (token_count >= MAX_TOKENS)
				finish_line();
			else
				mode = MODE_BETWEEN;
		endfunction

		// A held slash turns out to be an ordinary character.
		function void flush_slash();
			slash_held = 1'b0;
			if (mode == MODE_BETWEEN) begin
				token_count++;
				mode = MODE_PLAIN;
			end
			emit(KIND_CHAR, {3'd0, CH_SLASH}, cur_index());
		endfunction

		function bit is_separator(logic [7:0] c);
			return (c <= CH_SPACE) || (c >= CH_HIGH);
		endfunction

		function void dispatch(logic [7:0] c);
			case (mode)
				MODE_BETWEEN: begin
					if (c == CH_NUL) begin
						finish_line();
					end else if (is_separator(c)) begin
						// Separators between tokens are skipped.
					end else if (c == CH_QUOTE) begin
						token_count++;
						mode = MODE_QUOTED;
					end else if (c == CH_SLASH) begin
						slash_held = 1'b1;
					end else begin
						token_count++;
						mode = MODE_PLAIN;
						emit(KIND_CHAR, {3'd0, c}, cur_index());
					end
				end
				MODE_PLAIN: begin
					if (c == CH_NUL) begin
						end_token();
						finish_line();
					end else if (is_separator(c)) begin
						close_token();
					end else if (c == CH_QUOTE) begin
						close_token();
						if (mode != MODE_DONE) begin
							token_count++;
							mode = MODE_QUOTED;
						end
					end else if (c == CH_SLASH) begin
						slash_held = 1'b1;
					end else begin
						emit(KIND_CHAR, {3'd0, c}, cur_index());
					end
				end
				MODE_QUOTED: begin
					if (c == CH_NUL) begin
						end_token();
						finish_line();
					end else if (c == CH_QUOTE) begin
						close_token();
					end else begin
						emit(KIND_CHAR, {3'd0, c}, cur_index());
					end
				end
				MODE_COMMENT: begin
					if (c == CH_NUL)
						finish_line();
					else if (c == CH_STAR)
						mode = MODE_STAR;
				end
				MODE_STAR: begin
					if (c == CH_NUL)
						finish_line();
					else if (c == CH_SLASH)
						mode = MODE_BETWEEN;
					else if (c != CH_STAR)
						mode = MODE_COMMENT;
				end
				default: begin
					// Finished lines ignore the rest of their bytes.
				end
			endcase
		endfunction

		// Works out the results of one accepted byte and queues them.
		function void accept_byte(logic [7:0] c, logic l);
			byte_results.delete();
			if (slash_held) begin
				if (c == CH_SLASH) begin
					slash_held = 1'b0;
					if (mode == MODE_PLAIN)
						end_token();
					finish_line();
				end else if (c == CH_STAR) begin
					slash_held = 1'b0;
					if (mode == MODE_PLAIN)
						close_token();
					if (mode != MODE_DONE)
						mode = MODE_STAR;
				end else begin
					flush_slash();
					dispatch(c);
				end
			end else begin
				dispatch(c);
			end

			// The end of a line finishes it and brings back the reset state.
			if (l) begin
				if (mode != MODE_DONE) begin
					if (slash_held)
						flush_slash();
					if (mode == MODE_PLAIN || mode == MODE_QUOTED)
						end_token();
					finish_line();
				end
				mode = MODE_BETWEEN;
				slash_held = 1'b0;
				token_count = 0;
			end

			if (byte_results.size() > 0)
				byte_results[byte_results.size() - 1].run_last = 1'b1;
			foreach (byte_results[i])
				awaited.push_back(byte_results[i]);
		endfunction

		// Compares one transferred result with the oldest one awaited.
		function void check_result(kind_t k, logic [10:0] v, logic [9:0] idx,
				logic rl);
			token_result_t got;
			token_result_t want;
			bit none_awaited;
			bit bad;
			got.kind = k;
			got.value = v;
			got.token_index = idx;
			got.run_last = rl;
			none_awaited = (awaited.size() == 0);
			if (none_awaited) begin
				want = '0;
				bad = 1'b1;
			end else begin
				want = awaited.pop_front();
				bad = (want != got);
			end
			if (bad) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t ns: mismatch%s: expected %0d/%0d/%0d/%0b, got %0d/%0d/%0d/%0b",
						$time, none_awaited ? " (nothing awaited)" : "",
						want.kind, want.value, want.token_index, want.run_last,
						got.kind, got.value, got.token_index, got.run_last);
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [7:0]  ch = 8'd0;
	logic        last = 1'b0;
	logic        empty;
	logic        pop = 1'b0;
	logic [1:0]  kind;
	logic [10:0] value;
	logic [9:0]  token_index;
	logic        run_last;

	token_scoreboard sb;
	int send_idle_pct = 25;
	int recv_idle_pct = 63;
	int bytes_sent = 0;

	command_tokenizer_stream_unit #(
		.MAX_TOKENS(MAX_TOKENS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.ch(ch),
		.last(last),
		.empty(empty),
		.pop(pop),
		.kind(kind),
		.value(value),
		.token_index(token_index),
		.run_last(run_last)
	);

	// Clock with an 8 ns period.
	initial begin
		forever #4 clk = ~clk;
	end

	// Result side: check each transfer and stall at random.
	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			sb.check_result(kind_t'(kind), value, token_index, run_last);
		pop <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Watchdog: the run ends when nothing transfers for too long.
	initial begin
		int stall_cycles;
		stall_cycles = 0;
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("end of test: mismatches");
		$finish;
	end

	// Sends one byte, after a random idle gap, and waits for its transfer.
	task automatic send_byte(input logic [7:0] c, input logic l);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		ch <= c;
		last <= l;
		do
			@(posedge clk);
		while (full);
		sb.accept_byte(c, l);
		bytes_sent++;
	endtask

	// Sends a whole line; its final byte carries the last flag.
	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], i == s.len() - 1);
	endtask

	// Random line: mostly bytes with a meaning to the parser, sometimes noise.
	task automatic send_random_line();
		int len;
		int pick;
		bit noise;
		logic [7:0] c;
		len = $urandom_range(24, 1);
		noise = ($urandom_range(99) < 15);
		for (int i = 0; i < len; i++) begin
			pick = $urandom_range(99);
			if (noise)
				c = 8'($urandom_range(255));
			else if (pick < 35)
				c = 8'($urandom_range(8'h7F, 8'h21));
			else if (pick < 50)
				c = CH_SPACE;
			else if (pick < 62)
				c = CH_QUOTE;
			else if (pick < 77)
				c = CH_SLASH;
			else if (pick < 87)
				c = CH_STAR;
			else if (pick < 93)
				c = 8'($urandom_range(8'h1F, 8'h01));
			else if (pick < 97)
				c = 8'($urandom_range(8'hFF, 8'h80));
			else
				c = CH_NUL;
			send_byte(c, i == len - 1);
		end
	endtask

	task automatic send_random_lines(input int count);
		int start;
		start = bytes_sent;
		while (bytes_sent - start < count)
			send_random_line();
	endtask

	// Main sequence.
	initial begin
		sb = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Sender idles a quarter of the time, receiver most of the time.
		send_idle_pct = 25;
		recv_idle_pct = 63;

		// Quote ends a plain token, quoted spaces, slash flushed into a new
		// token, and a slash held at the end of the line.
		send_text("a\"b c\"/x/");
		// Empty quoted token, comment closed by its own star, line comment.
		send_text("\"\"/*/q/ //z");
		// Byte extremes, zero ending the string, bytes ignored after it.
		send_byte(8'hFF, 1'b0);
		send_byte(8'h7F, 1'b0);
		send_byte(8'h01, 1'b0);
		send_byte(CH_NUL, 1'b0);
		send_byte(CH_HIGH, 1'b1);
		// Quoted token left open at the end of the line.
		send_text("\"/*");

		send_random_lines(ITEMS_PER_PHASE);

		// Hold off until everything has drained, then swap the idle rates.
		push <= 1'b0;
		@(posedge clk);
		while (sb.awaited.size() != 0)
			@(posedge clk);
		send_idle_pct = 63;
		recv_idle_pct = 25;
		send_random_lines(ITEMS_PER_PHASE);

		// Full rate on both sides.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		send_random_lines(ITEMS_PER_PHASE);

		push <= 1'b0;
		while (sb.awaited.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.mismatches == 0 && sb.awaited.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
